/* hw/rtl/tsdz_pkg.sv */
package tsdz_pkg;

    localparam int unsigned FULL_SCALE_DEF = 32767;

    localparam int SAMPLE_W = 16;
    localparam int ZONE_W   = 15;
    localparam int CFG_W    = 15;
    localparam int INDEX_W  = 2;

    typedef enum logic [INDEX_W-1:0] {
        REG_ZONE_MODE  = 2'd0,
        REG_OUTER_ZONE = 2'd1,
        REG_LEFT_ZONE  = 2'd2,
        REG_RIGHT_ZONE = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_AXIAL  = 2'd1,
        MODE_RADIAL = 2'd2,
        MODE_SCALED = 2'd3
    } zone_mode_t;

    localparam zone_mode_t        MODE_RESET  = MODE_SCALED;
    localparam logic [ZONE_W-1:0] OUTER_RESET = 15'd3277;
    localparam logic [ZONE_W-1:0] LEFT_RESET  = 15'd7849;
    localparam logic [ZONE_W-1:0] RIGHT_RESET = 15'd8689;

    typedef struct packed {
        zone_mode_t        mode;
        logic [ZONE_W-1:0] outer;
    } zone_cfg_t;

endpackage

/* hw/rtl/tsdz_stick.sv */
module tsdz_stick
    import tsdz_pkg::*;
#(
    parameter int unsigned FULL_SCALE = FULL_SCALE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [SAMPLE_W-1:0] raw_x,
    input  logic signed [SAMPLE_W-1:0] raw_y,
    input  logic [ZONE_W-1:0]          inner_zone,
    input  zone_cfg_t                  zone_cfg,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] out_x,
    output logic signed [SAMPLE_W-1:0] out_y,
    output logic [ZONE_W-1:0]          level
);

    localparam int MAG_W   = 16;
    localparam int SQ_W    = 32;
    localparam int ROOT_W  = 24;
    localparam int REM_W   = 27;
    localparam int QUOT_W  = 16;
    localparam int FS_W    = $clog2(FULL_SCALE + 1);
    localparam int DEN_W   = FS_W + 8;
    localparam int CMP_W   = (DEN_W > ROOT_W) ? DEN_W : ROOT_W;

    localparam int ROOT_FIRST = 3;
    localparam int DSET       = ROOT_FIRST + ROOT_W;
    localparam int DIV_FIRST  = DSET + 1;
    localparam int ASET       = DIV_FIRST + QUOT_W;
    localparam int ADJ_FIRST  = ASET + 1;
    localparam int MUL        = ADJ_FIRST + ZONE_W;
    localparam int OUTS       = MUL + 1;
    localparam int NST        = OUTS + 1;

    localparam logic [CMP_W-1:0]  FS_SHIFTED = CMP_W'({FS_W'(FULL_SCALE), 8'd0});
    localparam logic [QUOT_W-1:0] POS_MAX    = 16'd32767;
    localparam logic [QUOT_W-1:0] NEG_MAX    = 16'd32768;
    localparam logic [ZONE_W-1:0] LEVEL_MAX  = 15'h7fff;

    typedef struct packed {
        logic                       sx;
        logic                       sy;
        logic                       past;
        logic                       below;
        logic [MAG_W-1:0]           ax;
        logic [MAG_W-1:0]           ay;
        logic [SQ_W-1:0]            sqx;
        logic [SQ_W-1:0]            sqy;
        logic [SQ_W-1:0]            sq;
        logic [REM_W-1:0]           rem;
        logic [ROOT_W-1:0]          root;
        logic [ROOT_W-1:0]          rx;
        logic [ROOT_W-1:0]          ry;
        logic [DEN_W-1:0]           rl;
        logic [QUOT_W-1:0]          qx;
        logic [QUOT_W-1:0]          qy;
        logic [QUOT_W-1:0]          ql;
        logic signed [SAMPLE_W-1:0] cx;
        logic signed [SAMPLE_W-1:0] cy;
        logic [ZONE_W-1:0]          lvl;
        logic [QUOT_W-1:0]          ra;
        logic [ZONE_W-1:0]          qa;
        logic [SQ_W-1:0]            px;
        logic [SQ_W-1:0]            py;
        logic signed [SAMPLE_W-1:0] ox;
        logic signed [SAMPLE_W-1:0] oy;
    } stage_t;

    stage_t           pipe_reg  [NST];
    stage_t           pipe_next [NST];
    logic [NST-1:0]   valid_reg;
    logic [NST-1:0]   valid_next;

    logic              fs_le_dz;
    logic [DEN_W-1:0]  den;
    logic [QUOT_W-1:0] adj_den;

    assign fs_le_dz = (32'(FULL_SCALE) <= 32'(inner_zone));
    assign den      = {FS_W'(FULL_SCALE) - FS_W'(inner_zone), 8'd0};
    assign adj_den  = QUOT_W'(17'd32768 - 17'(zone_cfg.outer));

    assign valid_next = {valid_reg[NST-2:0], in_valid};

    for (genvar i = 0; i < NST; i++)
    begin : g_stage
        if (i == 0)
        begin : g_in
            always_comb
            begin
                pipe_next[i]    = '0;
                pipe_next[i].sx = raw_x[SAMPLE_W-1];
                pipe_next[i].sy = raw_y[SAMPLE_W-1];
                pipe_next[i].ax = raw_x[SAMPLE_W-1] ? MAG_W'(-raw_x) : MAG_W'(raw_x);
                pipe_next[i].ay = raw_y[SAMPLE_W-1] ? MAG_W'(-raw_y) : MAG_W'(raw_y);
            end
        end
        else if (i == 1)
        begin : g_square
            always_comb
            begin
                pipe_next[i]     = pipe_reg[i-1];
                pipe_next[i].sqx = SQ_W'(pipe_reg[i-1].ax) * SQ_W'(pipe_reg[i-1].ax);
                pipe_next[i].sqy = SQ_W'(pipe_reg[i-1].ay) * SQ_W'(pipe_reg[i-1].ay);
            end
        end
        else if (i == 2)
        begin : g_sum
            always_comb
            begin
                pipe_next[i]      = pipe_reg[i-1];
                pipe_next[i].sq   = pipe_reg[i-1].sqx + pipe_reg[i-1].sqy;
                pipe_next[i].past = (pipe_reg[i-1].sqx + pipe_reg[i-1].sqy)
                                    > (SQ_W'(inner_zone) * SQ_W'(inner_zone));
                pipe_next[i].rem  = '0;
                pipe_next[i].root = '0;
            end
        end
        else if (i < DSET)
        begin : g_root
            localparam int J = ROOT_W - 1 - (i - ROOT_FIRST);
            logic [1:0]       pair;
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            logic             ge;

            // radicand is sq with sixteen zero bits below
            if (J >= 8)
            begin : g_pair
                assign pair = pipe_reg[i-1].sq[2*J-15 -: 2];
            end
            else
            begin : g_zero
                assign pair = 2'b00;
            end

            always_comb
            begin
                rem_sh            = {pipe_reg[i-1].rem[REM_W-3:0], pair};
                trial             = REM_W'({pipe_reg[i-1].root, 2'b01});
                ge                = (rem_sh >= trial);
                pipe_next[i]      = pipe_reg[i-1];
                pipe_next[i].rem  = ge ? rem_sh - trial : rem_sh;
                pipe_next[i].root = {pipe_reg[i-1].root[ROOT_W-2:0], ge};
            end
        end
        else if (i == DSET)
        begin : g_dset
            logic [CMP_W-1:0] mc;
            logic [CMP_W-1:0] num;

            always_comb
            begin
                mc  = (CMP_W'(pipe_reg[i-1].root) < FS_SHIFTED)
                      ? CMP_W'(pipe_reg[i-1].root) : FS_SHIFTED;
                num = mc - CMP_W'({inner_zone, 8'd0});
                pipe_next[i]    = pipe_reg[i-1];
                pipe_next[i].rx = ROOT_W'({pipe_reg[i-1].ax, 7'd0});
                pipe_next[i].ry = ROOT_W'({pipe_reg[i-1].ay, 7'd0});
                pipe_next[i].rl = DEN_W'(num >> 1);
                pipe_next[i].qx = '0;
                pipe_next[i].qy = '0;
                pipe_next[i].ql = {{(QUOT_W-1){1'b0}}, num[0]};
            end
        end
        else if (i < ASET)
        begin : g_div
            logic [ROOT_W:0] dv;
            logic [ROOT_W:0] shx;
            logic [ROOT_W:0] shy;
            logic [DEN_W:0]  shl;
            logic            gex;
            logic            gey;
            logic            gel;
            logic            bin;

            always_comb
            begin
                dv  = {1'b0, pipe_reg[i-1].root};
                shx = {pipe_reg[i-1].rx, 1'b0};
                shy = {pipe_reg[i-1].ry, 1'b0};
                bin = (i == DIV_FIRST) ? pipe_reg[i-1].ql[0] : 1'b0;
                shl = {pipe_reg[i-1].rl, bin};
                gex = (shx >= dv);
                gey = (shy >= dv);
                gel = (shl >= {1'b0, den});
                pipe_next[i]    = pipe_reg[i-1];
                pipe_next[i].rx = ROOT_W'(gex ? shx - dv : shx);
                pipe_next[i].ry = ROOT_W'(gey ? shy - dv : shy);
                pipe_next[i].rl = DEN_W'(gel ? shl - {1'b0, den} : shl);
                pipe_next[i].qx = {pipe_reg[i-1].qx[QUOT_W-2:0], gex};
                pipe_next[i].qy = {pipe_reg[i-1].qy[QUOT_W-2:0], gey};
                pipe_next[i].ql = {pipe_reg[i-1].ql[QUOT_W-2:0], gel};
            end
        end
        else if (i == ASET)
        begin : g_aset
            logic [ZONE_W-1:0] lv;

            always_comb
            begin
                lv = (fs_le_dz || pipe_reg[i-1].ql[QUOT_W-1])
                     ? LEVEL_MAX : pipe_reg[i-1].ql[ZONE_W-1:0];
                pipe_next[i]       = pipe_reg[i-1];
                pipe_next[i].cx    = pipe_reg[i-1].sx ? $signed(-pipe_reg[i-1].qx)
                    : $signed(pipe_reg[i-1].qx[QUOT_W-1] ? POS_MAX : pipe_reg[i-1].qx);
                pipe_next[i].cy    = pipe_reg[i-1].sy ? $signed(-pipe_reg[i-1].qy)
                    : $signed(pipe_reg[i-1].qy[QUOT_W-1] ? POS_MAX : pipe_reg[i-1].qy);
                pipe_next[i].lvl   = lv;
                pipe_next[i].below = (lv < zone_cfg.outer);
                pipe_next[i].ra    = (lv < zone_cfg.outer)
                                     ? '0 : QUOT_W'(lv - zone_cfg.outer);
                pipe_next[i].qa    = '0;
            end
        end
        else if (i < MUL)
        begin : g_adj
            logic [QUOT_W:0] sh;
            logic            ge;

            always_comb
            begin
                sh              = {pipe_reg[i-1].ra, 1'b0};
                ge              = (sh >= {1'b0, adj_den});
                pipe_next[i]    = pipe_reg[i-1];
                pipe_next[i].ra = QUOT_W'(ge ? sh - {1'b0, adj_den} : sh);
                pipe_next[i].qa = {pipe_reg[i-1].qa[ZONE_W-2:0], ge};
            end
        end
        else if (i == MUL)
        begin : g_mul
            logic [MAG_W-1:0] mx;
            logic [MAG_W-1:0] my;

            always_comb
            begin
                mx = pipe_reg[i-1].cx[SAMPLE_W-1] ? MAG_W'(-pipe_reg[i-1].cx)
                                                  : MAG_W'(pipe_reg[i-1].cx);
                my = pipe_reg[i-1].cy[SAMPLE_W-1] ? MAG_W'(-pipe_reg[i-1].cy)
                                                  : MAG_W'(pipe_reg[i-1].cy);
                pipe_next[i]    = pipe_reg[i-1];
                pipe_next[i].px = SQ_W'(mx) * SQ_W'(pipe_reg[i-1].qa);
                pipe_next[i].py = SQ_W'(my) * SQ_W'(pipe_reg[i-1].qa);
            end
        end
        else
        begin : g_out
            logic [MAG_W-1:0] mx;
            logic [MAG_W-1:0] my;
            logic [MAG_W-1:0] sxp;
            logic [MAG_W-1:0] syp;

            always_comb
            begin
                mx  = pipe_reg[i-1].cx[SAMPLE_W-1] ? MAG_W'(-pipe_reg[i-1].cx)
                                                   : MAG_W'(pipe_reg[i-1].cx);
                my  = pipe_reg[i-1].cy[SAMPLE_W-1] ? MAG_W'(-pipe_reg[i-1].cy)
                                                   : MAG_W'(pipe_reg[i-1].cy);
                sxp = pipe_reg[i-1].px[30:15];
                syp = pipe_reg[i-1].py[30:15];
                pipe_next[i] = pipe_reg[i-1];
                unique case (zone_cfg.mode)
                    MODE_NONE:
                    begin
                        pipe_next[i].ox = pipe_reg[i-1].cx;
                        pipe_next[i].oy = pipe_reg[i-1].cy;
                    end
                    MODE_AXIAL:
                    begin
                        pipe_next[i].ox = (mx < MAG_W'(zone_cfg.outer))
                                          ? '0 : pipe_reg[i-1].cx;
                        pipe_next[i].oy = (my < MAG_W'(zone_cfg.outer))
                                          ? '0 : pipe_reg[i-1].cy;
                    end
                    MODE_RADIAL:
                    begin
                        pipe_next[i].ox = pipe_reg[i-1].below ? '0 : pipe_reg[i-1].cx;
                        pipe_next[i].oy = pipe_reg[i-1].below ? '0 : pipe_reg[i-1].cy;
                    end
                    MODE_SCALED:
                    begin
                        pipe_next[i].ox = pipe_reg[i-1].below ? '0
                            : (pipe_reg[i-1].cx[SAMPLE_W-1] ? $signed(-sxp) : $signed(sxp));
                        pipe_next[i].oy = pipe_reg[i-1].below ? '0
                            : (pipe_reg[i-1].cy[SAMPLE_W-1] ? $signed(-syp) : $signed(syp));
                    end
                    default:
                    begin
                        pipe_next[i].ox = pipe_reg[i-1].cx;
                        pipe_next[i].oy = pipe_reg[i-1].cy;
                    end
                endcase
                // inside the inner zone everything reads zero
                if (!pipe_reg[i-1].past)
                begin
                    pipe_next[i].ox  = '0;
                    pipe_next[i].oy  = '0;
                    pipe_next[i].lvl = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_reg <= pipe_next;
    end

    assign out_valid = valid_reg[NST-1];
    assign out_x     = pipe_reg[NST-1].ox;
    assign out_y     = pipe_reg[NST-1].oy;
    assign level     = pipe_reg[NST-1].lvl;

    a_dir_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ASET-1] && pipe_reg[ASET-1].past
        |-> pipe_reg[ASET-1].qx <= NEG_MAX && pipe_reg[ASET-1].qy <= NEG_MAX)
        else $error("direction quotient out of range");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ASET-1] && pipe_reg[ASET-1].past && !fs_le_dz
        |-> pipe_reg[ASET-1].ql <= NEG_MAX)
        else $error("level quotient out of range");

    a_inner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NST-1] && !pipe_reg[NST-1].past
        |-> out_x == '0 && out_y == '0 && level == '0)
        else $error("inner zone word not zero");

endmodule

/* hw/rtl/thumbstick_dead_zone_unit.sv */
// Two-stick dead-zone conditioner. A word is taken on every cycle with start high (busy
// stays low), so sample pairs may follow back to back, one per cycle. Each result word
// appears on done for exactly one cycle; the receiver cannot hold it off and must take it
// then. The pipeline runs the 24-step magnitude root, the 16-step direction and level
// dividers and the 15-step scaling divider, each one step per stage. Configuration
// writes land at once and must be made by the user only while no word is in flight;
// the block itself does not enforce this.
module thumbstick_dead_zone_unit
    import tsdz_pkg::*;
#(
    parameter int unsigned SAMPLE_FULL_SCALE = FULL_SCALE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       cfg_we,
    input  logic [INDEX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic signed [SAMPLE_W-1:0] left_raw_x,
    input  logic signed [SAMPLE_W-1:0] left_raw_y,
    input  logic signed [SAMPLE_W-1:0] right_raw_x,
    input  logic signed [SAMPLE_W-1:0] right_raw_y,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] left_out_x,
    output logic signed [SAMPLE_W-1:0] left_out_y,
    output logic [ZONE_W-1:0]          left_level,
    output logic signed [SAMPLE_W-1:0] right_out_x,
    output logic signed [SAMPLE_W-1:0] right_out_y,
    output logic [ZONE_W-1:0]          right_level
);

    zone_mode_t        mode_reg;
    logic [ZONE_W-1:0] outer_reg;
    logic [ZONE_W-1:0] left_zone_reg;
    logic [ZONE_W-1:0] right_zone_reg;
    zone_cfg_t         zone_cfg;
    logic              accept;
    logic              left_valid;
    logic              right_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_RESET;
            outer_reg      <= OUTER_RESET;
            left_zone_reg  <= LEFT_RESET;
            right_zone_reg <= RIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_ZONE_MODE:  mode_reg       <= zone_mode_t'(cfg_data[1:0]);
                REG_OUTER_ZONE: outer_reg      <= cfg_data;
                REG_LEFT_ZONE:  left_zone_reg  <= cfg_data;
                REG_RIGHT_ZONE: right_zone_reg <= cfg_data;
                default:        mode_reg       <= mode_reg;
            endcase
        end
    end

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign zone_cfg = '{mode: mode_reg, outer: outer_reg};

    tsdz_stick #(
        .FULL_SCALE (SAMPLE_FULL_SCALE)
    ) u_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .raw_x      (left_raw_x),
        .raw_y      (left_raw_y),
        .inner_zone (left_zone_reg),
        .zone_cfg   (zone_cfg),
        .out_valid  (left_valid),
        .out_x      (left_out_x),
        .out_y      (left_out_y),
        .level      (left_level)
    );

    tsdz_stick #(
        .FULL_SCALE (SAMPLE_FULL_SCALE)
    ) u_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .raw_x      (right_raw_x),
        .raw_y      (right_raw_y),
        .inner_zone (right_zone_reg),
        .zone_cfg   (zone_cfg),
        .out_valid  (right_valid),
        .out_x      (right_out_x),
        .out_y      (right_out_y),
        .level      (right_level)
    );

    assign done = left_valid && right_valid;

endmodule

/* tb/thumbstick_dead_zone_unit_tb.sv */
module thumbstick_dead_zone_unit_tb;
    import tsdz_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FULL_SCALE = FULL_SCALE_DEF;
    localparam int          LATENCY    = 62;
    localparam int          STALL_MAX  = 4000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic [ZONE_W-1:0]          level;
    } stick_t;

    typedef struct packed {
        stick_t left;
        stick_t right;
    } stick_pair_t;

    class stick_scoreboard;
        zone_mode_t        mode;
        logic [ZONE_W-1:0] outer;
        logic [ZONE_W-1:0] left_zone;
        logic [ZONE_W-1:0] right_zone;
        stick_pair_t       pending_words[$];
        int                mismatches;
        int                words_checked;

        function new();
            mode          = MODE_RESET;
            outer         = OUTER_RESET;
            left_zone     = LEFT_RESET;
            right_zone    = RIGHT_RESET;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_ZONE_MODE:  mode = zone_mode_t'(val[1:0]);
                REG_OUTER_ZONE: outer = val;
                REG_LEFT_ZONE:  left_zone = val;
                REG_RIGHT_ZONE: right_zone = val;
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned magnitude(longint c);
            return (c < 0) ? longint'(-c) : longint'(c);
        endfunction

        function longint unit_component(longint c, longint unsigned m8);
            longint unsigned q;
            q = (magnitude(c) << 23) / m8;
            if (c < 0)
            begin
                if (q > 32768)
                    q = 32768;
                return -longint'(q);
            end
            if (q > 32767)
                q = 32767;
            return longint'(q);
        endfunction

        function longint scale_component(longint c, longint unsigned adj);
            longint unsigned p;
            p = (magnitude(c) * adj) >> 15;
            return (c < 0) ? -longint'(p) : longint'(p);
        endfunction

        function stick_t condition_stick(logic signed [SAMPLE_W-1:0] rx,
                                         logic signed [SAMPLE_W-1:0] ry,
                                         logic [ZONE_W-1:0] zone);
            stick_t          s;
            longint unsigned sq;
            longint unsigned m8;
            longint unsigned mc;
            longint unsigned lv;
            longint unsigned adj;
            longint unsigned dz;
            longint unsigned oz;
            longint          cx;
            longint          cy;
            s  = '0;
            dz = zone;
            oz = outer;
            sq = magnitude(rx) * magnitude(rx) + magnitude(ry) * magnitude(ry);
            if (sq <= dz * dz)
                return s;
            m8 = int_sqrt(sq << 16);
            cx = unit_component(rx, m8);
            cy = unit_component(ry, m8);
            if (FULL_SCALE <= dz)
                lv = 32767;
            else
            begin
                mc = (m8 < (longint'(FULL_SCALE) << 8)) ? m8 : (longint'(FULL_SCALE) << 8);
                lv = ((mc - (dz << 8)) << 15) / ((FULL_SCALE - dz) << 8);
                if (lv > 32767)
                    lv = 32767;
            end
            case (mode)
                MODE_AXIAL:
                begin
                    if (magnitude(cx) < oz)
                        cx = 0;
                    if (magnitude(cy) < oz)
                        cy = 0;
                end
                MODE_RADIAL:
                    if (lv < oz)
                    begin
                        cx = 0;
                        cy = 0;
                    end
                MODE_SCALED:
                    if (lv < oz)
                    begin
                        cx = 0;
                        cy = 0;
                    end
                    else
                    begin
                        adj = ((lv - oz) << 15) / (32768 - oz);
                        cx  = scale_component(cx, adj);
                        cy  = scale_component(cy, adj);
                    end
                default: ;
            endcase
            s.x     = cx[SAMPLE_W-1:0];
            s.y     = cy[SAMPLE_W-1:0];
            s.level = lv[ZONE_W-1:0];
            return s;
        endfunction

        function void note_word(logic signed [SAMPLE_W-1:0] lx,
                                logic signed [SAMPLE_W-1:0] ly,
                                logic signed [SAMPLE_W-1:0] rx,
                                logic signed [SAMPLE_W-1:0] ry);
            stick_pair_t p;
            p.left  = condition_stick(lx, ly, left_zone);
            p.right = condition_stick(rx, ry, right_zone);
            pending_words.push_back(p);
        endfunction

        function void check_word(stick_pair_t got);
            stick_pair_t want;
            words_checked++;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word %0d with nothing expected", words_checked);
                return;
            end
            want = pending_words.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"word %0d: expected L(%0d,%0d,%0d) R(%0d,%0d,%0d)",
                              " got L(%0d,%0d,%0d) R(%0d,%0d,%0d)"},
                             words_checked,
                             want.left.x, want.left.y, want.left.level,
                             want.right.x, want.right.y, want.right.level,
                             got.left.x, got.left.y, got.left.level,
                             got.right.x, got.right.y, got.right.level);
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       cfg_we;
    logic [INDEX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic signed [SAMPLE_W-1:0] left_raw_x;
    logic signed [SAMPLE_W-1:0] left_raw_y;
    logic signed [SAMPLE_W-1:0] right_raw_x;
    logic signed [SAMPLE_W-1:0] right_raw_y;
    logic                       done;
    logic signed [SAMPLE_W-1:0] left_out_x;
    logic signed [SAMPLE_W-1:0] left_out_y;
    logic [ZONE_W-1:0]          left_level;
    logic signed [SAMPLE_W-1:0] right_out_x;
    logic signed [SAMPLE_W-1:0] right_out_y;
    logic [ZONE_W-1:0]          right_level;

    stick_scoreboard sb;
    int              idle_cycles;

    thumbstick_dead_zone_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .left_raw_x  (left_raw_x),
        .left_raw_y  (left_raw_y),
        .right_raw_x (right_raw_x),
        .right_raw_y (right_raw_y),
        .done        (done),
        .left_out_x  (left_out_x),
        .left_out_y  (left_out_y),
        .left_level  (left_level),
        .right_out_x (right_out_x),
        .right_out_y (right_out_y),
        .right_level (right_level)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word({left_out_x, left_out_y, left_level,
                           right_out_x, right_out_y, right_level});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // word is left driven; the caller lowers start or drives the next one
    task automatic send_word(logic signed [SAMPLE_W-1:0] lx,
                             logic signed [SAMPLE_W-1:0] ly,
                             logic signed [SAMPLE_W-1:0] rx,
                             logic signed [SAMPLE_W-1:0] ry);
        @(negedge clk);
        start       = 1'b1;
        left_raw_x  = lx;
        left_raw_y  = ly;
        right_raw_x = rx;
        right_raw_y = ry;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_word(lx, ly, rx, ry);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain();
        pause_sender(0);
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int zone);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2: return SAMPLE_W'($urandom());
            3, 4:    return SAMPLE_W'($urandom_range(0, 2 * zone + 2) - zone - 1);
            5:       return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            6:       return SAMPLE_W'($urandom_range(0, 2) - 1);
            default: return SAMPLE_W'($urandom_range(0, 4 * zone + 4) - 2 * zone - 2);
        endcase
    endfunction

    task automatic random_phase(int words);
        int sent;
        int burst;
        sent = 0;
        while (sent < words)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < words)
            begin
                send_word(pick_sample(sb.left_zone), pick_sample(sb.left_zone),
                          pick_sample(sb.right_zone), pick_sample(sb.right_zone));
                burst--;
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 20));
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_ZONE_MODE;
        cfg_data    = '0;
        left_raw_x  = '0;
        left_raw_y  = '0;
        right_raw_x = '0;
        right_raw_y = '0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zone edges, full-length components
        send_word(0, 0, 0, 0);
        send_word(16'sh7fff, 0, 16'sh8000, 0);
        send_word(0, 16'sh8000, 0, 16'sh7fff);
        send_word(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_word(7849, 0, 8689, 0);
        send_word(7850, 0, 0, -8690);
        send_word(-1, 1, 1, -1);
        send_word(5550, 5551, 6144, 6145);
        send_word(16'sh8000, 16'sh7fff, 1000, -32000);
        send_word(23170, -23170, -23171, 23171);
        pause_sender(0);
        drain();

        write_reg(REG_ZONE_MODE, CFG_W'(MODE_NONE));
        write_reg(REG_OUTER_ZONE, 0);
        write_reg(REG_LEFT_ZONE, 0);
        write_reg(REG_RIGHT_ZONE, 32766);
        send_word(0, 0, 16'sh8000, 0);
        send_word(1, 0, 32766, 0);
        send_word(16'sh8000, 16'sh8000, 32767, 1);
        send_word(-1, -1, 0, 16'sh8000);
        random_phase(240);
        drain();

        write_reg(REG_ZONE_MODE, CFG_W'(MODE_AXIAL));
        write_reg(REG_OUTER_ZONE, 32767);
        send_word(16'sh8000, 0, 16'sh8000, 16'sh8000);
        send_word(16'sh7fff, 1, 0, 0);
        random_phase(200);
        drain();

        write_reg(REG_OUTER_ZONE, 8000);
        write_reg(REG_LEFT_ZONE, 4000);
        write_reg(REG_RIGHT_ZONE, 1);
        random_phase(260);
        drain();

        write_reg(REG_ZONE_MODE, CFG_W'(MODE_RADIAL));
        write_reg(REG_OUTER_ZONE, 16000);
        random_phase(250);
        drain();
        write_reg(REG_OUTER_ZONE, 0);
        write_reg(REG_LEFT_ZONE, 32766);
        write_reg(REG_RIGHT_ZONE, 0);
        random_phase(200);
        drain();

        write_reg(REG_ZONE_MODE, CFG_W'(MODE_SCALED));
        write_reg(REG_OUTER_ZONE, 32767);
        send_word(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        random_phase(150);
        drain();

        write_reg(REG_OUTER_ZONE, 0);
        write_reg(REG_LEFT_ZONE, 0);
        write_reg(REG_RIGHT_ZONE, 20000);
        random_phase(250);
        drain();

        write_reg(REG_OUTER_ZONE, CFG_W'($urandom_range(1, 32766)));
        write_reg(REG_LEFT_ZONE, CFG_W'($urandom_range(0, 32766)));
        write_reg(REG_RIGHT_ZONE, CFG_W'($urandom_range(0, 32766)));
        random_phase(200);
        drain();

        write_reg(REG_OUTER_ZONE, OUTER_RESET);
        write_reg(REG_LEFT_ZONE, LEFT_RESET);
        write_reg(REG_RIGHT_ZONE, RIGHT_RESET);
        random_phase(180);
        drain();

        if (sb.mismatches == 0 && sb.pending_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
